// ----- design/ntew_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ntew_pkg
// shared types and word codes for the number-to-english-words core
// ----------------------------------------------------------------------------
package ntew_pkg;

  localparam int NUM_GROUPS = 4;
  localparam int GROUP_W    = 12;                  // three bcd digits per group
  localparam int BCD_W      = NUM_GROUPS * GROUP_W;
  localparam int CODE_W     = 5;

  localparam logic [CODE_W-1:0] CODE_ZERO      = 5'd0;
  localparam logic [CODE_W-1:0] CODE_TEN       = 5'd10;
  localparam logic [CODE_W-1:0] CODE_TENS_BASE = 5'd18;
  localparam logic [CODE_W-1:0] CODE_HUNDRED   = 5'd28;

  typedef enum logic [2:0] {
    STEP_HDIGIT,
    STEP_HUNDRED,
    STEP_TENS,
    STEP_UNIT,
    STEP_SCALE
  } step_t;

  typedef struct packed {
    logic        load;
    logic        shift;
    logic        emit;
    logic        emit_zero;
    logic [1:0]  grp;
    step_t       step;
  } cmd_t;

  typedef struct packed {
    logic in_zero;
    logic grp_zero;
  } sts_t;

endpackage
`default_nettype wire

// ----- design/ntew_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ntew_dp
// datapath: shift-and-add-3 binary to bcd, token decode, output register
// ----------------------------------------------------------------------------
module ntew_dp #(
  parameter int INPUT_BITS = 31
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [INPUT_BITS-1:0]         in_value,
  input  wire ntew_pkg::cmd_t                cmd,
  output ntew_pkg::sts_t                     sts,
  output logic                               out_valid,
  output logic [ntew_pkg::CODE_W-1:0]        out_word_code,
  output logic                               out_last
);
  import ntew_pkg::*;

  logic [INPUT_BITS-1:0] val_r, val_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt, bcd_adj;
  logic                  out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]     code_r, code_nxt;
  logic                  last_r, last_nxt;

  logic [GROUP_W-1:0]    grp_dig [NUM_GROUPS];
  logic [NUM_GROUPS-1:0] grp_nz;
  logic [NUM_GROUPS-1:0] lower_zero;
  logic [GROUP_W-1:0]    cur;
  logic [3:0]            h, t, u;
  logic                  rest_nz, g0;
  logic                  tok_valid, tok_last;
  logic [CODE_W-1:0]     tok_code;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < BCD_W / 4; d++) begin
      bcd_adj[d*4 +: 4] = (bcd_r[d*4 +: 4] >= 4'd5) ? bcd_r[d*4 +: 4] + 4'd3
                                                     : bcd_r[d*4 +: 4];
    end
  end

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_dig[g] = bcd_r[g*GROUP_W +: GROUP_W];
      grp_nz[g]  = |bcd_r[g*GROUP_W +: GROUP_W];
    end
    lower_zero[0] = 1'b1;
    for (int g = 1; g < NUM_GROUPS; g++) begin
      lower_zero[g] = lower_zero[g-1] & ~grp_nz[g-1];
    end
  end

  assign cur     = grp_dig[cmd.grp];
  assign h       = cur[11:8];
  assign t       = cur[7:4];
  assign u       = cur[3:0];
  assign rest_nz = (t != 4'd0) || (u != 4'd0);
  assign g0      = (cmd.grp == 2'd0);

  assign sts.in_zero  = (in_value == '0);
  assign sts.grp_zero = ~grp_nz[cmd.grp];

  // token for the selected group and step
  always_comb begin
    tok_valid = 1'b0;
    tok_code  = CODE_ZERO;
    tok_last  = 1'b0;
    case (cmd.step)
      STEP_HDIGIT: begin
        tok_valid = (h != 4'd0);
        tok_code  = {1'b0, h};
      end
      STEP_HUNDRED: begin
        tok_valid = (h != 4'd0);
        tok_code  = CODE_HUNDRED;
        tok_last  = !rest_nz && g0;
      end
      STEP_TENS: begin
        if (t >= 4'd2) begin
          tok_valid = 1'b1;
          tok_code  = CODE_TENS_BASE + {1'b0, t};
          tok_last  = (u == 4'd0) && g0;
        end else begin
          tok_valid = rest_nz;
          tok_code  = t[0] ? CODE_TEN + {1'b0, u} : {1'b0, u};
          tok_last  = g0;
        end
      end
      STEP_UNIT: begin
        tok_valid = (t >= 4'd2) && (u != 4'd0);
        tok_code  = {1'b0, u};
        tok_last  = g0;
      end
      STEP_SCALE: begin
        tok_valid = !g0 && grp_nz[cmd.grp];
        tok_code  = CODE_HUNDRED + {3'b000, cmd.grp};
        tok_last  = lower_zero[cmd.grp];
      end
      default: begin
        tok_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    val_nxt       = val_r;
    bcd_nxt       = bcd_r;
    out_valid_nxt = 1'b0;
    code_nxt      = code_r;
    last_nxt      = last_r;
    if (cmd.load) begin
      val_nxt = in_value;
      bcd_nxt = '0;
    end else if (cmd.shift) begin
      val_nxt = {val_r[INPUT_BITS-2:0], 1'b0};
      bcd_nxt = {bcd_adj[BCD_W-2:0], val_r[INPUT_BITS-1]};
    end
    if (cmd.emit_zero) begin
      out_valid_nxt = 1'b1;
      code_nxt      = CODE_ZERO;
      last_nxt      = 1'b1;
    end else if (cmd.emit && tok_valid) begin
      out_valid_nxt = 1'b1;
      code_nxt      = tok_code;
      last_nxt      = tok_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    val_r  <= val_nxt;
    bcd_r  <= bcd_nxt;
    code_r <= code_nxt;
    last_r <= last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_word_code = code_r;
  assign out_last      = last_r;

endmodule
`default_nettype wire

// ----- design/ntew_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ntew_ctrl
// controller: conversion bit count, then walk of groups and token steps
// ----------------------------------------------------------------------------
module ntew_ctrl #(
  parameter int INPUT_BITS = 31
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire ntew_pkg::sts_t sts,
  output ntew_pkg::cmd_t      cmd
);
  import ntew_pkg::*;

  localparam int CNT_W = $clog2(INPUT_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]      grp_r, grp_nxt;
  step_t           step_r, step_nxt;
  logic            busy_r, busy_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    grp_nxt       = grp_r;
    step_nxt      = step_r;
    cmd.load      = 1'b0;
    cmd.shift     = 1'b0;
    cmd.emit      = 1'b0;
    cmd.emit_zero = 1'b0;
    cmd.grp       = grp_r;
    cmd.step      = step_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (sts.in_zero) begin
            cmd.emit_zero = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(INPUT_BITS - 1)) begin
          grp_nxt   = 2'd3;
          step_nxt  = STEP_HDIGIT;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (step_r == STEP_SCALE || (step_r == STEP_HDIGIT && sts.grp_zero)) begin
          step_nxt = STEP_HDIGIT;
          grp_nxt  = grp_r - 2'd1;
          if (grp_r == 2'd0) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          case (step_r)
            STEP_HDIGIT:  step_nxt = STEP_HUNDRED;
            STEP_HUNDRED: step_nxt = STEP_TENS;
            STEP_TENS:    step_nxt = STEP_UNIT;
            default:      step_nxt = STEP_SCALE;
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      grp_r   <= 2'd0;
      step_r  <= STEP_HDIGIT;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      grp_r   <= grp_nxt;
      step_r  <= step_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule
`default_nettype wire

// ----- design/number_to_english_words_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// number_to_english_words_core
// reads a non-negative integer out as english word tokens, most significant first
// ----------------------------------------------------------------------------
// a zero input gives its single token in the cycle after the transfer;
// otherwise bcd conversion runs first, one bit per cycle, then the token
// walk: hundreds digit, hundred, tens, unit and scale steps for each nonzero
// base-1000 group, only the first step for a zero group; busy stays high
// through conversion and walk, and no new input is taken until the walk ends
// reset: rst_n synchronous, clears the controller and the output strobe;
// results go out as one-cycle strobes, the receiver cannot stall
module number_to_english_words_core #(
  parameter int INPUT_BITS = 31
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input channel: transfer when start is high and busy is low
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [INPUT_BITS-1:0]  in_value,
  // result channel: one token per out_valid strobe
  output logic                        out_valid,
  output logic [ntew_pkg::CODE_W-1:0] out_word_code,
  output logic                        out_last
);
  import ntew_pkg::*;

  // command and status between the controller and the datapath
  cmd_t cmd;
  sts_t sts;

  // controller: counts conversion bits, then steps through groups
  // (billion down to units) and per-group token slots
  ntew_ctrl #(
    .INPUT_BITS (INPUT_BITS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // datapath: serial binary to bcd, token decode per slot, output register
  ntew_dp #(
    .INPUT_BITS (INPUT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_word_code (out_word_code),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire
